/* rtl/core/cleq_pkg.sv */
// Shared types, sizes and codes of the credit limited event queue.
package cleq_pkg;

	// Queue geometry and limits
	localparam int unsigned QUEUE_ENTRIES   = 256;
	localparam int unsigned EVENT_KINDS     = 32;
	localparam logic [23:0] MAX_QUEUE_BYTES = 24'hFFFFFF;
	localparam int unsigned QA_W            = $clog2(QUEUE_ENTRIES);
	localparam int unsigned QC_W            = QA_W + 1;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned CFG_DATA_W      = 32;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUBSCRIBE_MASK = 3'd0,
		CFG_QUEUE_LIMIT    = 3'd1,
		CFG_RESERVED_BYTES = 3'd2,
		CFG_OVERFLOW_LEN   = 3'd3,
		CFG_REMOVED_LEN    = 3'd4
	} cfg_idx_t;

	// Request kinds of an input transaction
	typedef enum logic [1:0] {
		KIND_EVENT  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [3:0] {
		ST_DELIVERED = 4'd0,
		ST_EMPTY     = 4'd1,
		ST_GONE      = 4'd2,
		ST_SHORT     = 4'd3,
		ST_FAULT     = 4'd4,
		ST_QUEUED    = 4'd5,
		ST_DROPPED   = 4'd6,
		ST_UNSUB     = 4'd7,
		ST_IGNORED   = 4'd8,
		ST_REMOVED   = 4'd9
	} status_t;

	// Record kinds held in the queue
	typedef enum logic [1:0] {
		RK_EVENT   = 2'd0,
		RK_MARKER  = 2'd1,
		RK_REMOVED = 2'd2
	} rkind_t;

	// One queue entry
	typedef struct packed {
		rkind_t      rk;
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] tag;
	} entry_t;

	// One input transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  event_id;
		logic [15:0] event_len;
		logic [15:0] event_tag;
		logic        spare_available;
		logic [15:0] read_capacity;
		logic        copy_fails;
	} item_t;

	// One result transaction
	typedef struct packed {
		status_t     status;
		rkind_t      record_kind;
		logic [31:0] record_seq;
		logic [15:0] record_len;
		logic [15:0] record_tag;
		logic [31:0] first_dropped_seq;
		logic [31:0] last_dropped_seq;
		logic [31:0] drop_count;
		logic        readable;
		logic        hangup;
		logic [23:0] bytes_charged;
	} result_t;

	// Control from the step logic to the entry store
	typedef struct packed {
		logic            push;
		logic [QA_W-1:0] push_addr;
		entry_t          push_entry;
		logic            push_empty;
		logic            pop;
	} store_ctl_t;

endpackage

/* rtl/core/cleq_store.sv */
// Entry memory of the queue with a prefetched head entry.
module cleq_store import cleq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  store_ctl_t      ctl,
	input  logic [QA_W-1:0] head,
	output entry_t          head_entry
);

	entry_t mem [QUEUE_ENTRIES];
	entry_t next_q;
	entry_t hold_q;
	logic   use_next_q;

	// Write pushed entries, prefetch the entry after the head
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[ctl.push_addr] <= ctl.push_entry;
		end
		next_q <= mem[head + QA_W'(1)];
	end

	// Select the prefetched entry right after a pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_next_q <= 1'b0;
		end else begin
			use_next_q <= ctl.pop;
		end
	end

	// Hold the head entry, load it directly when pushing into an empty queue
	always_ff @(posedge clk) begin
		hold_q <= ctl.push_empty ? ctl.push_entry : head_entry;
	end

	assign head_entry = use_next_q ? next_q : hold_q;

endmodule

/* rtl/core/cleq_ctrl.sv */
// Configuration registers, queue state and the per-transaction step logic.
module cleq_ctrl import cleq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  step,
	input  item_t                 item,
	input  entry_t                head_entry,
	output logic [QA_W-1:0]       head,
	output store_ctl_t            ctl,
	output result_t               res
);

	// Configuration
	logic [31:0] sub_mask_q;
	logic [23:0] queue_limit_q;
	logic [16:0] reserved_q;
	logic [15:0] ovf_len_q;
	logic [15:0] rem_len_q;

	// Queue state
	logic [QA_W-1:0] fifo_head_q, fifo_head_d;
	logic [QC_W-1:0] fifo_count_q, fifo_count_d;
	logic [31:0]     last_seq_q, last_seq_d;
	logic [23:0]     charged_q, charged_d;
	logic            epoch_open_q, epoch_open_d;
	logic [31:0]     epoch_first_q, epoch_first_d;
	logic [31:0]     epoch_last_q, epoch_last_d;
	logic [31:0]     epoch_drops_q, epoch_drops_d;
	logic            dead_q, dead_d;

	logic [23:0]     limit;
	logic [25:0]     need;
	logic            wanted;
	logic            no_slot;
	logic [31:0]     seq;
	logic [15:0]     rlen;
	logic            push_c;
	logic            pop_c;
	entry_t          push_entry;
	logic [24:0]     total;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_mask_q    <= '0;
			queue_limit_q <= 24'd262144;
			reserved_q    <= '0;
			ovf_len_q     <= '0;
			rem_len_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SUBSCRIBE_MASK: sub_mask_q    <= cfg_wdata[31:0];
				CFG_QUEUE_LIMIT:    queue_limit_q <= cfg_wdata[23:0];
				CFG_RESERVED_BYTES: reserved_q    <= cfg_wdata[16:0];
				CFG_OVERFLOW_LEN:   ovf_len_q     <= cfg_wdata[15:0];
				CFG_REMOVED_LEN:    rem_len_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Admission terms of an arriving event
	assign limit   = (queue_limit_q > MAX_QUEUE_BYTES) ? MAX_QUEUE_BYTES : queue_limit_q;
	assign need    = 26'(charged_q) + 26'(reserved_q) + 26'(item.event_len);
	assign wanted  = (32'(item.event_id) < EVENT_KINDS) && sub_mask_q[item.event_id];
	assign no_slot = (32'(fifo_count_q) + 32'd2) >= QUEUE_ENTRIES;
	assign seq     = last_seq_q + 32'd1;
	assign rlen    = (head_entry.rk == RK_MARKER) ? ovf_len_q : head_entry.len;

	// Work out one transaction
	always_comb begin
		fifo_head_d   = fifo_head_q;
		fifo_count_d  = fifo_count_q;
		last_seq_d    = last_seq_q;
		charged_d     = charged_q;
		epoch_open_d  = epoch_open_q;
		epoch_first_d = epoch_first_q;
		epoch_last_d  = epoch_last_q;
		epoch_drops_d = epoch_drops_q;
		dead_d        = dead_q;
		push_c        = 1'b0;
		pop_c         = 1'b0;
		push_entry    = '0;
		res           = '0;
		res.status    = ST_IGNORED;
		case (item.kind)
			KIND_EVENT: begin
				if (dead_q) begin
					res.status = ST_IGNORED;
				end else if (!wanted) begin
					res.status = ST_UNSUB;
				end else begin
					last_seq_d = seq;
					if (epoch_open_q || !item.spare_available ||
						need > 26'(limit) || no_slot) begin
						// Drop: open an epoch with a marker, or extend it
						res.status   = ST_DROPPED;
						epoch_last_d = seq;
						if (!epoch_open_q) begin
							epoch_open_d  = 1'b1;
							epoch_first_d = seq;
							epoch_drops_d = 32'd1;
							push_c        = 1'b1;
							push_entry.rk = RK_MARKER;
						end else begin
							epoch_drops_d = epoch_drops_q + 32'd1;
						end
					end else begin
						res.status     = ST_QUEUED;
						charged_d      = 24'(need - 26'(reserved_q));
						push_c         = 1'b1;
						push_entry.rk  = RK_EVENT;
						push_entry.seq = seq;
						push_entry.len = item.event_len;
						push_entry.tag = item.event_tag;
					end
				end
			end
			KIND_READ: begin
				if (fifo_count_q == '0) begin
					res.status = dead_q ? ST_GONE : ST_EMPTY;
				end else if (rlen > item.read_capacity) begin
					res.status = ST_SHORT;
				end else if (item.copy_fails) begin
					res.status = ST_FAULT;
				end else begin
					res.status      = ST_DELIVERED;
					res.record_kind = head_entry.rk;
					res.record_len  = rlen;
					pop_c           = 1'b1;
					if (head_entry.rk == RK_MARKER) begin
						// Report the epoch and close it
						res.record_seq        = epoch_first_q;
						res.first_dropped_seq = epoch_first_q;
						res.last_dropped_seq  = epoch_last_q;
						res.drop_count        = epoch_drops_q;
						epoch_open_d          = 1'b0;
						epoch_drops_d         = '0;
					end else begin
						res.record_seq = head_entry.seq;
						if (head_entry.rk == RK_EVENT) begin
							res.record_tag = head_entry.tag;
							charged_d = (charged_q >= 24'(rlen)) ?
								charged_q - 24'(rlen) : '0;
						end
					end
				end
			end
			KIND_REMOVE: begin
				if (!dead_q) begin
					res.status     = ST_REMOVED;
					last_seq_d     = seq;
					dead_d         = 1'b1;
					push_c         = 1'b1;
					push_entry.rk  = RK_REMOVED;
					push_entry.seq = seq;
					push_entry.len = rem_len_q;
				end
			end
			default: ;
		endcase

		// Drop a push when every slot is taken
		if (push_c && fifo_count_q >= QC_W'(QUEUE_ENTRIES)) begin
			push_c = 1'b0;
		end
		if (push_c) begin
			fifo_count_d = fifo_count_q + QC_W'(1);
		end
		if (pop_c) begin
			fifo_head_d  = fifo_head_q + QA_W'(1);
			fifo_count_d = fifo_count_q - QC_W'(1);
		end

		res.readable      = (fifo_count_d != '0);
		res.hangup        = dead_d;
		total             = 25'(charged_d) + 25'(reserved_q);
		res.bytes_charged = total[24] ? 24'hFFFFFF : total[23:0];
	end

	// Drive the entry store
	always_comb begin
		ctl            = '0;
		ctl.push       = step && push_c;
		ctl.push_addr  = fifo_head_q + fifo_count_q[QA_W-1:0];
		ctl.push_entry = push_entry;
		ctl.push_empty = step && push_c && (fifo_count_q == '0);
		ctl.pop        = step && pop_c;
	end

	assign head = fifo_head_q;

	// Advance the queue state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_head_q   <= '0;
			fifo_count_q  <= '0;
			last_seq_q    <= '0;
			charged_q     <= '0;
			epoch_open_q  <= 1'b0;
			epoch_first_q <= '0;
			epoch_last_q  <= '0;
			epoch_drops_q <= '0;
			dead_q        <= 1'b0;
		end else if (step) begin
			fifo_head_q   <= fifo_head_d;
			fifo_count_q  <= fifo_count_d;
			last_seq_q    <= last_seq_d;
			charged_q     <= charged_d;
			epoch_open_q  <= epoch_open_d;
			epoch_first_q <= epoch_first_d;
			epoch_last_q  <= epoch_last_d;
			epoch_drops_q <= epoch_drops_d;
			dead_q        <= dead_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count_q <= QC_W'(QUEUE_ENTRIES))
		else $error("queue count beyond depth");

	a_epoch_marker: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_open_q |-> (fifo_count_q != '0) && (epoch_drops_q != '0))
		else $error("open drop epoch without a queued marker or drops");

	a_queued_grows: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status == ST_QUEUED |=> fifo_count_q == $past(fifo_count_q) + QC_W'(1))
		else $error("queued event did not take a slot");

	a_dead_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(dead_q))
		else $error("device removal flag cleared");

	a_delivered_pops: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status == ST_DELIVERED |=> fifo_head_q == $past(fifo_head_q) + QA_W'(1))
		else $error("delivered record did not advance the head");
`endif

endmodule

/* rtl/core/credit_limited_event_queue_unit.sv */
// Top level of the credit limited event queue: stream ports, input and result registers.
// Takes one transaction per clock cycle when the result side keeps up; each accepted input
// transaction is loaded into the input register, and its result into the result register
// when the result side can take it. The rate is set by the single step stage, which reads a
// prefetched head entry and updates all queue state at once, and by the entry memory's one
// write and one registered read port.
// No clearing pass follows reset: entries are read only after they were written.
module credit_limited_event_queue_unit import cleq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// event_id[4:0], event_len[20:5], event_tag[36:21], spare_available[37],
	// read_capacity[53:38], copy_fails[54], zero[55]
	input  logic [55:0]           s_tdata,
	// kind[1:0]
	input  logic [1:0]            s_tuser,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// record_seq[31:0], record_len[47:32], record_tag[63:48], first_dropped_seq[95:64],
	// last_dropped_seq[127:96], drop_count[159:128], readable[160], hangup[161],
	// bytes_charged[185:162], zero[191:186]
	output logic [191:0]          m_tdata,
	// status[3:0], record_kind[5:4]
	output logic [5:0]            m_tuser
);

	logic            in_valid_s1;
	item_t           item_s1;
	item_t           item_in;
	logic            out_valid_q;
	result_t         out_q;
	logic            advance;
	logic            step;
	result_t         res;
	logic [QA_W-1:0] head;
	store_ctl_t      ctl;
	entry_t          head_entry;

	// Unpack the input transaction
	assign item_in.kind            = s_tuser;
	assign item_in.event_id        = s_tdata[4:0];
	assign item_in.event_len       = s_tdata[20:5];
	assign item_in.event_tag       = s_tdata[36:21];
	assign item_in.spare_available = s_tdata[37];
	assign item_in.read_capacity   = s_tdata[53:38];
	assign item_in.copy_fails      = s_tdata[54];

	assign advance  = !out_valid_q || m_tready;
	assign step     = in_valid_s1 && advance;
	assign s_tready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	cleq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.step       (step),
		.item       (item_s1),
		.head_entry (head_entry),
		.head       (head),
		.ctl        (ctl),
		.res        (res)
	);

	cleq_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.head       (head),
		.head_entry (head_entry)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	// Pack the result transaction
	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_q.record_kind, out_q.status};
	assign m_tdata  = {6'd0, out_q.bytes_charged, out_q.hangup, out_q.readable,
		out_q.drop_count, out_q.last_dropped_seq, out_q.first_dropped_seq,
		out_q.record_tag, out_q.record_len, out_q.record_seq};

endmodule

/* tb/event_queue_checker.sv */
// Checker for the credit limited event queue: tracks registers, predicts and compares results.
`timescale 1ns / 1ps
module event_queue_checker import cleq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [55:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [191:0]          m_tdata,
	input  logic [5:0]            m_tuser,
	output int unsigned           pending,
	output int unsigned           mismatches
);

	// Register copies
	logic [31:0] sub_mask;
	logic [23:0] q_limit;
	logic [16:0] resv;
	logic [15:0] ovf_len;
	logic [15:0] rem_len;

	// Shadow of the record FIFO and its bookkeeping
	rkind_t          store_kind [QUEUE_ENTRIES];
	logic [31:0]     store_seq  [QUEUE_ENTRIES];
	logic [15:0]     store_len  [QUEUE_ENTRIES];
	logic [15:0]     store_tag  [QUEUE_ENTRIES];
	logic [QA_W-1:0] head;
	logic [QC_W-1:0] fill;
	logic [31:0]     last_seq;
	logic [23:0]     charged;
	logic            epoch_open;
	logic            dead;
	logic [31:0]     epoch_first;
	logic [31:0]     epoch_last;
	logic [31:0]     epoch_drops;

	result_t     due_results [$];
	int unsigned err_cnt;
	int unsigned result_no;

	// Append one record at the tail; a full FIFO keeps what it has
	function automatic void push_record(input rkind_t rk, input logic [31:0] seq,
			input logic [15:0] len, input logic [15:0] tag);
		logic [QA_W-1:0] slot;
		if (32'(fill) >= QUEUE_ENTRIES)
			return;
		slot = head + fill[QA_W-1:0];
		store_kind[slot] = rk;
		store_seq[slot]  = seq;
		store_len[slot]  = len;
		store_tag[slot]  = tag;
		fill = fill + 1'b1;
	endfunction

	// Apply one request to the shadow queue and return the result it yields
	function automatic result_t step_queue(input item_t rq);
		result_t     r;
		logic [31:0] seq;
		logic [24:0] need;
		logic [24:0] total;
		logic [15:0] rlen;
		rkind_t      rk;
		r = '0;
		r.status = ST_IGNORED;
		case (rq.kind)
		KIND_EVENT: begin
			if (dead) begin
				r.status = ST_IGNORED;
			end else if (!sub_mask[rq.event_id]) begin
				r.status = ST_UNSUB;
			end else begin
				last_seq = last_seq + 1;
				seq = last_seq;
				need = 25'(charged) + 25'(resv) + 25'(rq.event_len);
				if (epoch_open || !rq.spare_available || need > 25'(q_limit) ||
						32'(fill) + 2 >= QUEUE_ENTRIES) begin
					// open a drop epoch with one marker, or extend the open one
					if (!epoch_open) begin
						epoch_open  = 1'b1;
						epoch_first = seq;
						epoch_drops = '0;
						push_record(RK_MARKER, '0, '0, '0);
					end
					epoch_last  = seq;
					epoch_drops = epoch_drops + 1;
					r.status = ST_DROPPED;
				end else begin
					charged = charged + 24'(rq.event_len);
					push_record(RK_EVENT, seq, rq.event_len, rq.event_tag);
					r.status = ST_QUEUED;
				end
			end
		end
		KIND_READ: begin
			if (fill == '0) begin
				r.status = dead ? ST_GONE : ST_EMPTY;
			end else begin
				rk = store_kind[head];
				rlen = (rk == RK_MARKER) ? ovf_len : store_len[head];
				if (rlen > rq.read_capacity) begin
					r.status = ST_SHORT;
				end else if (rq.copy_fails) begin
					r.status = ST_FAULT;
				end else begin
					r.status      = ST_DELIVERED;
					r.record_kind = rk;
					r.record_len  = rlen;
					if (rk == RK_MARKER) begin
						// report the epoch and close it
						r.record_seq        = epoch_first;
						r.first_dropped_seq = epoch_first;
						r.last_dropped_seq  = epoch_last;
						r.drop_count        = epoch_drops;
						epoch_open  = 1'b0;
						epoch_drops = '0;
					end else begin
						r.record_seq = store_seq[head];
						if (rk == RK_EVENT) begin
							r.record_tag = store_tag[head];
							charged = (charged >= 24'(rlen)) ? charged - 24'(rlen) : '0;
						end
					end
					head = head + 1'b1;
					fill = fill - 1'b1;
				end
			end
		end
		KIND_REMOVE: begin
			if (!dead) begin
				last_seq = last_seq + 1;
				push_record(RK_REMOVED, last_seq, rem_len, '0);
				dead = 1'b1;
				r.status = ST_REMOVED;
			end
		end
		default: r.status = ST_IGNORED;
		endcase
		total = 25'(charged) + 25'(resv);
		r.readable      = (fill != '0);
		r.hangup        = dead;
		r.bytes_charged = total[24] ? 24'hFFFFFF : total[23:0];
		return r;
	endfunction

	// Count one differing field, show the first few
	task automatic note_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("mismatch on result %0d, %s: expected %0h, got %0h",
					result_no, name, want_v, got_v);
		end
	endtask

	// Watch the configuration port and both streams
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		item_t   rq;
		if (!arst_n) begin
			sub_mask    = '0;
			q_limit     = 24'd262144;
			resv        = '0;
			ovf_len     = '0;
			rem_len     = '0;
			head        = '0;
			fill        = '0;
			last_seq    = '0;
			charged     = '0;
			epoch_open  = 1'b0;
			dead        = 1'b0;
			epoch_first = '0;
			epoch_last  = '0;
			epoch_drops = '0;
			err_cnt     = 0;
			result_no   = 0;
			due_results.delete();
		end else begin
			// register writes take effect at once
			if (cfg_wr_en) begin
				case (cfg_index)
				CFG_SUBSCRIBE_MASK: sub_mask = cfg_wdata;
				CFG_QUEUE_LIMIT:    q_limit  = cfg_wdata[23:0];
				CFG_RESERVED_BYTES: resv     = cfg_wdata[16:0];
				CFG_OVERFLOW_LEN:   ovf_len  = cfg_wdata[15:0];
				CFG_REMOVED_LEN:    rem_len  = cfg_wdata[15:0];
				default: ;
				endcase
			end
			// compare a result transaction with the oldest expectation
			if (m_tvalid && m_tready) begin
				got = '0;
				got.status            = status_t'(m_tuser[3:0]);
				got.record_kind       = rkind_t'(m_tuser[5:4]);
				got.record_seq        = m_tdata[31:0];
				got.record_len        = m_tdata[47:32];
				got.record_tag        = m_tdata[63:48];
				got.first_dropped_seq = m_tdata[95:64];
				got.last_dropped_seq  = m_tdata[127:96];
				got.drop_count        = m_tdata[159:128];
				got.readable          = m_tdata[160];
				got.hangup            = m_tdata[161];
				got.bytes_charged     = m_tdata[185:162];
				if (due_results.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("result %0d arrived with nothing expected", result_no);
				end else begin
					want = due_results.pop_front();
					note_field("status", 32'(want.status), 32'(got.status));
					note_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
					note_field("record_seq", want.record_seq, got.record_seq);
					note_field("record_len", 32'(want.record_len), 32'(got.record_len));
					note_field("record_tag", 32'(want.record_tag), 32'(got.record_tag));
					note_field("first_dropped_seq", want.first_dropped_seq,
						got.first_dropped_seq);
					note_field("last_dropped_seq", want.last_dropped_seq,
						got.last_dropped_seq);
					note_field("drop_count", want.drop_count, got.drop_count);
					note_field("readable", 32'(want.readable), 32'(got.readable));
					note_field("hangup", 32'(want.hangup), 32'(got.hangup));
					note_field("bytes_charged", 32'(want.bytes_charged),
						32'(got.bytes_charged));
				end
				result_no++;
			end
			// predict the result of an accepted request
			if (s_tvalid && s_tready) begin
				rq.kind            = s_tuser;
				rq.event_id        = s_tdata[4:0];
				rq.event_len       = s_tdata[20:5];
				rq.event_tag       = s_tdata[36:21];
				rq.spare_available = s_tdata[37];
				rq.read_capacity   = s_tdata[53:38];
				rq.copy_fails      = s_tdata[54];
				due_results.push_back(step_queue(rq));
			end
		end
		pending    <= due_results.size();
		mismatches <= err_cnt;
	end

endmodule

/* tb/credit_limited_event_queue_unit_tb.sv */
// Testbench top of the credit limited event queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module credit_limited_event_queue_unit_tb;
	import cleq_pkg::*;

	localparam logic [1:0] KIND_UNUSED    = 2'd3;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SUBSCRIBE_MASK;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [55:0]           s_tdata   = '0;
	logic [1:0]            s_tuser   = KIND_EVENT;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [191:0]          m_tdata;
	logic [5:0]            m_tuser;

	int unsigned pending;
	int unsigned mismatches;
	int unsigned gap_pct     = 0;
	int unsigned stall_pct   = 0;
	int unsigned quiet_count = 0;

	credit_limited_event_queue_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	event_queue_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.pending    (pending),
		.mismatches (mismatches)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side in random bursts
	initial begin
		@(posedge clk);
		forever begin
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic item_t make_item(input logic [1:0] kind, input logic [4:0] idx,
			input logic [15:0] len, input logic [15:0] tag, input logic spare,
			input logic [15:0] cap, input logic fails);
		item_t it;
		it.kind            = kind;
		it.event_id        = idx;
		it.event_len       = len;
		it.event_tag       = tag;
		it.spare_available = spare;
		it.read_capacity   = cap;
		it.copy_fails      = fails;
		return it;
	endfunction

	// Arriving event: mostly with a spare, lengths biased to zero, max and small values
	function automatic item_t rand_event(input int unsigned len_hi);
		logic [15:0] len;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			len = '0;
		else if (roll < 14)
			len = 16'hFFFF;
		else
			len = 16'($urandom_range(0, len_hi));
		return make_item(KIND_EVENT, 5'($urandom), len, 16'($urandom),
			$urandom_range(0, 99) < 90, 16'($urandom), 1'($urandom));
	endfunction

	// Reader request: mostly a large buffer and no fault
	function automatic item_t rand_read();
		logic [15:0] cap;
		cap = ($urandom_range(0, 99) < 80) ? 16'hFFFF : 16'($urandom);
		return make_item(KIND_READ, 5'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), cap, $urandom_range(0, 99) < 8);
	endfunction

	// Drive one request and hold it until accepted
	task automatic send_item(input item_t it);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {1'b0, it.copy_fails, it.read_capacity, it.spare_available,
			it.event_tag, it.event_len, it.event_id};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all registers while the block is idle
	task automatic program_regs(input logic [31:0] mask, input logic [23:0] limit,
			input logic [16:0] resv, input logic [15:0] ovf, input logic [15:0] rem);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SUBSCRIBE_MASK;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_index <= CFG_QUEUE_LIMIT;
		cfg_wdata <= 32'(limit);
		@(posedge clk);
		cfg_index <= CFG_RESERVED_BYTES;
		cfg_wdata <= 32'(resv);
		@(posedge clk);
		cfg_index <= CFG_OVERFLOW_LEN;
		cfg_wdata <= 32'(ovf);
		@(posedge clk);
		cfg_index <= CFG_REMOVED_LEN;
		cfg_wdata <= 32'(rem);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus and verdict
	initial begin
		logic [31:0] mask;
		logic [23:0] limit;
		logic [16:0] resv;
		logic [15:0] ovf;
		logic [15:0] rem;
		int unsigned len_hi;
		int unsigned burst_hi;
		int unsigned n_items;
		int unsigned sent;
		int unsigned blen;
		int unsigned roll;
		int unsigned j;
		logic        fill_burst;
		item_t       it;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: nothing subscribed, empty queue, unused kind code
		send_item(make_item(KIND_EVENT, 5'd31, 16'd8, 16'h1234, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(KIND_UNUSED, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		drain();

		// Tight budget: limit edge, drop epochs, short buffer, fault, marker read
		program_regs(32'hFFFF_FFFF, 24'd256, 17'd16, 16'd24, 16'hFFFF);
		send_item(make_item(KIND_EVENT, 5'd0, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_EVENT, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
		send_item(make_item(KIND_EVENT, 5'd5, 16'd8, 16'h0101, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b1));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd24, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(KIND_EVENT, 5'd7, 16'd240, 16'hA5A5, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_EVENT, 5'd8, 16'd1, 16'h0001, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(KIND_EVENT, 5'd9, 16'd0, 16'h0002, 1'b0, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'hFFFF, 1'b0));
		send_item(make_item(KIND_EVENT, 5'd10, 16'd16, 16'h5A5A, 1'b1, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd15, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd16, 1'b0));
		send_item(make_item(KIND_UNUSED, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
		drain();

		// Random phases: bursts of arrivals that fill the queue, bursts of reads that drain it
		for (int unsigned phase = 0; phase < 7; phase++) begin
			n_items = 210;
			case (phase)
			0: begin
				mask = 32'hFFFF_FFFF; limit = 24'hFFFFFF; resv = '0; ovf = '0; rem = '0;
				len_hi = 64; burst_hi = 300; gap_pct = 0; stall_pct = 0;
			end
			1: begin
				mask = $urandom; limit = 24'($urandom_range(1000, 5000));
				resv = 17'($urandom_range(0, 500)); ovf = 16'($urandom); rem = 16'($urandom);
				len_hi = 400; burst_hi = 40; gap_pct = 10; stall_pct = 10;
			end
			2: begin
				mask = $urandom | 32'h1; limit = '0; resv = '0;
				ovf = 16'($urandom_range(0, 64)); rem = '0;
				len_hi = 4; burst_hi = 20; gap_pct = 25; stall_pct = 5;
			end
			3: begin
				mask = '0; limit = 24'($urandom); resv = 17'($urandom_range(0, 131070));
				ovf = 16'($urandom); rem = 16'($urandom);
				len_hi = 1000; burst_hi = 30; gap_pct = 5; stall_pct = 25; n_items = 50;
			end
			4: begin
				mask = 32'hFFFF_FFFF; limit = 24'hFFFFFF; resv = 17'd131070;
				ovf = 16'hFFFF; rem = 16'hFFFF;
				len_hi = 16'hFFFF; burst_hi = 120; gap_pct = 15; stall_pct = 15;
			end
			5: begin
				mask = $urandom; limit = 24'($urandom); resv = 17'($urandom_range(0, 131070));
				ovf = 16'($urandom); rem = 16'($urandom);
				len_hi = 2000; burst_hi = 60; gap_pct = 30; stall_pct = 30;
			end
			default: begin
				mask = 32'hFFFF_FFFF; limit = 24'($urandom_range(20000, 60000));
				resv = 17'($urandom_range(0, 131070)); ovf = 16'($urandom);
				rem = 16'($urandom);
				len_hi = 1000; burst_hi = 200; gap_pct = 8; stall_pct = 8;
			end
			endcase
			program_regs(mask, limit, resv, ovf, rem);
			sent = 0;
			while (sent < n_items) begin
				fill_burst = 1'($urandom);
				blen = $urandom_range(1, burst_hi);
				for (j = 0; j < blen && sent < n_items; j++) begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						it = make_item(KIND_UNUSED, 5'($urandom), 16'($urandom),
							16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
					else if (fill_burst ? roll < 88 : roll < 15)
						it = rand_event(len_hi);
					else
						it = rand_read();
					send_item(it);
					sent++;
				end
			end
			drain();
		end

		// Last part, no idling: device removal, arrivals after it, then drain to the end
		gap_pct   = 0;
		stall_pct = 0;
		program_regs(32'hFFFF_FFFF, 24'hFFFFFF, 17'($urandom_range(0, 131070)),
			16'($urandom), 16'($urandom));
		repeat (4) send_item(rand_event(3000));
		send_item(make_item(KIND_REMOVE, 5'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), 16'($urandom), 1'($urandom)));
		repeat (2) send_item(rand_event(3000));
		send_item(make_item(KIND_REMOVE, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		send_item(make_item(KIND_UNUSED, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		send_item(make_item(KIND_READ, 5'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0));
		repeat (300) send_item(rand_read());
		drain();

		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
